[sv/c3x3f_pkg.sv]
// shared constants and types for the 3x3 streaming image filter
// used by conv3x3_image_filter_top, no dependencies
package c3x3f_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;
    localparam int GEOM_W    = 12;
    localparam int SUM_W     = 14;

    typedef logic [7:0] t_pix;

    // kernel select codes
    localparam logic [2:0] K_BOX       = 3'd0;
    localparam logic [2:0] K_GAUSS     = 3'd1;
    localparam logic [2:0] K_PREWITT_X = 3'd2;
    localparam logic [2:0] K_PREWITT_Y = 3'd3;
    localparam logic [2:0] K_SOBEL_X   = 3'd4;
    localparam logic [2:0] K_SOBEL_Y   = 3'd5;
    localparam logic [2:0] K_LAPLACE8  = 3'd6;
    localparam logic [2:0] K_LAPLACE9  = 3'd7;

    // register indexes on the apb port
    localparam logic [1:0] REG_KERNEL = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [GEOM_W-1:0] WIDTH_RST  = GEOM_W'(640);
    localparam logic [GEOM_W-1:0] HEIGHT_RST = GEOM_W'(480);
    localparam logic [GEOM_W-1:0] GEOM_MIN   = GEOM_W'(3);
    localparam logic [GEOM_W-1:0] WIDTH_MAX  = GEOM_W'(MAX_WIDTH);

    // box: floor(s * 0.11111) as s * BOX_RECIP >> BOX_SHIFT, exact for s up to 2295
    localparam int               BOX_SHIFT = 30;
    localparam logic [26:0]      BOX_RECIP = 27'd119303454;
    // divide by 3 as v * 683 >> 11, exact for v up to 765
    localparam int               DIV3_SHIFT = 11;
    localparam logic [9:0]       DIV3_RECIP = 10'd683;

endpackage

[sv/conv3x3_image_filter_top.sv]
// streaming 3x3 image filter: line stores, window, kernel datapath and apb registers
// depends on c3x3f_pkg
// Grey pixels enter in raster order, one per clock when nothing stalls, and each
// pixel whose 3x3 neighborhood is complete (column and row at least 2) yields one
// filtered result for the interior pixel one column and one row back; border pixels
// give none. Throughput is one pixel per cycle, set by one read and one write of each
// line store per pixel; a result passes the stage 1, kernel sum and output registers.
// frame_start restarts the position counters on its pixel. Kernel and geometry are
// to be written over the apb port only while no pixel is in flight; the block itself
// does not enforce this. The line stores have no clearing pass and need none: every
// entry is written in the first rows of a frame before it feeds a result.
module conv3x3_image_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pixel_in,
    input  logic        i_frame_start,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_filtered_value,
    output logic [10:0] o_out_x,
    output logic [11:0] o_out_y,
    output logic        o_frame_done,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = c3x3f_pkg::COL_W;
    localparam int RW = c3x3f_pkg::ROW_W;
    localparam int GW = c3x3f_pkg::GEOM_W;
    localparam int SW = c3x3f_pkg::SUM_W;

    // configuration registers
    logic [2:0]    r_kernel;
    logic [GW-1:0] r_width;
    logic [GW-1:0] r_height;

    // position counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    // line stores: mid holds the previous row, top the row before it
    c3x3f_pkg::t_pix mem_mid [c3x3f_pkg::MAX_WIDTH];
    c3x3f_pkg::t_pix mem_top [c3x3f_pkg::MAX_WIDTH];
    c3x3f_pkg::t_pix r_rd_mid;
    c3x3f_pkg::t_pix r_rd_top;

    // stage 1: pixel with its line store data
    logic            r_v1;
    c3x3f_pkg::t_pix r_p1;
    logic [CW-1:0]   r_x1;
    logic [RW-1:0]   r_y1;
    logic            r_emit1;
    logic            r_done1;
    logic            r_fwd;
    c3x3f_pkg::t_pix r_fwd_mid;
    c3x3f_pkg::t_pix r_fwd_top;

    // window columns: c0 oldest, c1 middle; index 0 top row
    c3x3f_pkg::t_pix r_c0 [3];
    c3x3f_pkg::t_pix r_c1 [3];

    // stage 2: kernel sum
    logic              r_v2;
    logic signed [SW-2:0] r_sum2;
    logic [CW-1:0]     r_ox2;
    logic [RW-1:0]     r_oy2;
    logic              r_done2;

    // output register
    logic              r_ov;
    c3x3f_pkg::t_pix   r_oval;
    logic [CW-1:0]     r_ox;
    logic [RW-1:0]     r_oy;
    logic              r_odone;

    // handshake
    logic adv_o;
    logic ready2;
    logic ready1;
    logic s1_leave;
    logic acc_in;

    assign adv_o    = !r_ov || !i_stall;
    assign ready2   = !r_v2 || adv_o;
    assign s1_leave = r_v1 && ready2;
    assign ready1   = !r_v1 || ready2;
    assign acc_in   = i_valid && ready1;
    assign o_stall  = !ready1;

    // apb port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= c3x3f_pkg::K_BOX;
            r_width  <= c3x3f_pkg::WIDTH_RST;
            r_height <= c3x3f_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                c3x3f_pkg::REG_KERNEL: r_kernel <= pwdata[2:0];
                c3x3f_pkg::REG_WIDTH:  r_width  <= pwdata[GW-1:0];
                c3x3f_pkg::REG_HEIGHT: r_height <= pwdata[GW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            c3x3f_pkg::REG_KERNEL: prdata = {29'b0, r_kernel};
            c3x3f_pkg::REG_WIDTH:  prdata = {{(32-GW){1'b0}}, r_width};
            c3x3f_pkg::REG_HEIGHT: prdata = {{(32-GW){1'b0}}, r_height};
            default:               prdata = '0;
        endcase
    end

    // geometry limits and position of the incoming pixel
    logic [GW-1:0] w_lim;
    logic [GW-1:0] h_lim;
    logic [GW-1:0] w_m1;
    logic [GW-1:0] h_m1;
    logic [CW-1:0] x_in;
    logic [RW-1:0] y_in;
    logic          col_end;
    logic          row_end;

    always_comb begin
        if (r_width < c3x3f_pkg::GEOM_MIN) begin
            w_lim = c3x3f_pkg::GEOM_MIN;
        end else if (r_width > c3x3f_pkg::WIDTH_MAX) begin
            w_lim = c3x3f_pkg::WIDTH_MAX;
        end else begin
            w_lim = r_width;
        end
        h_lim = (r_height < c3x3f_pkg::GEOM_MIN) ? c3x3f_pkg::GEOM_MIN : r_height;
        w_m1  = w_lim - GW'(1);
        h_m1  = h_lim - GW'(1);
        x_in  = i_frame_start ? '0 : r_col;
        y_in  = i_frame_start ? '0 : r_row;
        col_end = GW'(x_in) >= w_m1;
        row_end = GW'(y_in) >= h_m1;
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : y_in + RW'(1);
        end else begin
            n_col = x_in + CW'(1);
            n_row = y_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc_in) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line store data seen by the stage 1 pixel, with bypass of a write to the same column
    c3x3f_pkg::t_pix mid_1;
    c3x3f_pkg::t_pix top_1;
    assign mid_1 = r_fwd ? r_fwd_mid : r_rd_mid;
    assign top_1 = r_fwd ? r_fwd_top : r_rd_top;

    always_ff @(posedge i_clk) begin
        if (s1_leave) begin
            mem_mid[r_x1] <= r_p1;
        end
        if (acc_in) begin
            r_rd_mid <= mem_mid[x_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_leave) begin
            mem_top[r_x1] <= mid_1;
        end
        if (acc_in) begin
            r_rd_top <= mem_top[x_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ready1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_p1      <= i_pixel_in;
            r_x1      <= x_in;
            r_y1      <= y_in;
            r_emit1   <= (x_in >= CW'(2)) && (y_in >= RW'(2));
            r_done1   <= col_end && row_end;
            // a column read now while the same column is written gets the new data
            r_fwd     <= s1_leave && (x_in == r_x1);
            r_fwd_mid <= r_p1;
            r_fwd_top <= mid_1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_c0[r] <= '0;
                r_c1[r] <= '0;
            end
        end else if (s1_leave) begin
            for (int r = 0; r < 3; r++) begin
                r_c0[r] <= r_c1[r];
            end
            r_c1[0] <= top_1;
            r_c1[1] <= mid_1;
            r_c1[2] <= r_p1;
        end
    end

    // kernel sum over the window
    logic signed [SW-1:0] w00, w01, w02, w10, w11, w12, w20, w21, w22;
    logic signed [SW-1:0] ring;
    logic signed [SW-1:0] n_sum;

    always_comb begin
        w00 = SW'(r_c0[0]);
        w10 = SW'(r_c0[1]);
        w20 = SW'(r_c0[2]);
        w01 = SW'(r_c1[0]);
        w11 = SW'(r_c1[1]);
        w21 = SW'(r_c1[2]);
        w02 = SW'(top_1);
        w12 = SW'(mid_1);
        w22 = SW'(r_p1);
        ring = w00 + w01 + w02 + w10 + w12 + w20 + w21 + w22;
        case (r_kernel)
            c3x3f_pkg::K_BOX:
                n_sum = ring + w11;
            c3x3f_pkg::K_GAUSS:
                n_sum = w00 + (w01 <<< 1) + w02 + (w10 <<< 1) + (w11 <<< 2)
                      + (w12 <<< 1) + w20 + (w21 <<< 1) + w22;
            c3x3f_pkg::K_PREWITT_X:
                n_sum = (w02 + w12 + w22) - (w00 + w10 + w20);
            c3x3f_pkg::K_PREWITT_Y:
                n_sum = (w20 + w21 + w22) - (w00 + w01 + w02);
            c3x3f_pkg::K_SOBEL_X:
                n_sum = (w02 + (w12 <<< 1) + w22) - (w00 + (w10 <<< 1) + w20);
            c3x3f_pkg::K_SOBEL_Y:
                n_sum = (w20 + (w21 <<< 1) + w22) - (w00 + (w01 <<< 1) + w02);
            c3x3f_pkg::K_LAPLACE8:
                n_sum = (w11 <<< 3) - ring;
            default:
                n_sum = (w11 <<< 3) + w11 - ring;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ready2) begin
            r_v2 <= s1_leave && r_emit1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r_sum2  <= n_sum[SW-2:0];
            r_ox2   <= r_x1 - CW'(1);
            r_oy2   <= r_y1 - RW'(1);
            r_done2 <= r_done1;
        end
    end

    // scaling of the sum into an 8-bit value
    logic [SW-3:0] mag;
    logic [38:0]   box_prod;
    logic [19:0]   div3_prod;
    c3x3f_pkg::t_pix n_val;

    always_comb begin
        mag       = r_sum2[SW-2] ? (SW-2)'(-r_sum2) : (SW-2)'(r_sum2);
        box_prod  = 39'(r_sum2[SW-3:0]) * 39'(c3x3f_pkg::BOX_RECIP);
        div3_prod = 20'(mag[9:0]) * 20'(c3x3f_pkg::DIV3_RECIP);
        case (r_kernel) inside
            c3x3f_pkg::K_BOX:
                n_val = box_prod[c3x3f_pkg::BOX_SHIFT +: 8];
            c3x3f_pkg::K_GAUSS:
                n_val = r_sum2[11:4];
            c3x3f_pkg::K_PREWITT_X, c3x3f_pkg::K_PREWITT_Y:
                n_val = div3_prod[c3x3f_pkg::DIV3_SHIFT +: 8];
            c3x3f_pkg::K_SOBEL_X, c3x3f_pkg::K_SOBEL_Y:
                n_val = mag[9:2];
            c3x3f_pkg::K_LAPLACE8:
                n_val = mag[10:3];
            default: begin
                if (r_sum2[SW-2]) begin
                    n_val = '0;
                end else if (r_sum2 > (SW-1)'(255)) begin
                    n_val = 8'hFF;
                end else begin
                    n_val = r_sum2[7:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv_o) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_o && r_v2) begin
            r_oval  <= n_val;
            r_ox    <= r_ox2;
            r_oy    <= r_oy2;
            r_odone <= r_done2;
        end
    end

    assign o_valid          = r_ov;
    assign o_filtered_value = r_oval;
    assign o_out_x          = r_ox;
    assign o_out_y          = r_oy;
    assign o_frame_done     = r_odone;

endmodule

[sv/c3x3f_checker.sv]
// port checker for conv3x3_image_filter_top, attached by the bind at the end
// depends only on the top level's ports
module c3x3f_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_filtered_value,
    input logic [10:0] o_out_x,
    input logic [11:0] o_out_y,
    input logic        o_frame_done
);

    // no result survives a reset
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_filtered_value) && $stable(o_out_x)
            && $stable(o_out_y) && $stable(o_frame_done))
        else $error("result payload changed while stalled");

    // pixels in column 0 or row 0 never get a result
    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_x != 11'd0 && o_out_y != 12'd0)
        else $error("result for a border pixel");

endmodule

bind conv3x3_image_filter_top c3x3f_checker u_c3x3f_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_filtered_value (o_filtered_value),
    .o_out_x          (o_out_x),
    .o_out_y          (o_out_y),
    .o_frame_done     (o_frame_done)
);
